>>> sv/fts_pkg.sv
// Package for the FIFO task scheduler: request, status and task state codes,
// port field widths and parameter defaults. No dependencies.
package fts_pkg;

    localparam int MAX_TASKS_DEF   = 512;
    localparam int QUEUE_DEPTH_DEF = 1024;

    localparam int REQ_W   = 3;
    localparam int IDX_W   = 9;
    localparam int STAT_W  = 3;
    localparam int TST_W   = 2;
    localparam int WOKEN_W = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE   = 3'd0,
        REQ_DISPATCH = 3'd1,
        REQ_YIELD    = 3'd2,
        REQ_AWAIT    = 3'd3,
        REQ_FINISH   = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        RES_OK      = 3'd0,
        RES_EMPTY   = 3'd1,
        RES_FULL    = 3'd2,
        RES_NORUN   = 3'd3,
        RES_BUSY    = 3'd4,
        RES_UNKNOWN = 3'd5
    } res_t;

    typedef enum logic [TST_W-1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_WAITING = 2'd2,
        ST_DONE    = 2'd3
    } tstate_t;

endpackage

>>> sv/fifo_task_scheduler_with_await.sv
// Top level of the FIFO task scheduler with await: sequencer, task table and
// run queue. Depends on fts_pkg and fts_ram.
//
// Usage:
//  - Input channel s_*: one request item (s_req_type, s_task_index) per
//    handshake. s_ready is high while the sequencer is idle.
//  - Result channel m_*: exactly one result item per request, in order.
//  - Sequence: create, dispatch, yield and await go through S_EXEC, S_RPT
//    and S_RES from accept to m_valid; the sequencer is idle again in that
//    same cycle, so a new item is taken only after the last result is loaded.
//    The states are set by the registered reads of the task table (one to
//    decide, one to report the addressed task's state).
//  - Finish of the running task walks the task table once to count waiters
//    and, with queue room, again to wake them: one entry a cycle via the table RAM port.
//  - Reset (aresetn low, synchronous) empties the queue, clears the task
//    count and the running task. RAM contents are not cleared; only the data of
//    created entries and of queue slots within the fill is ever used.
//  - Receiver stall: the result waits in the output register; the block
//    still accepts the next item and holds its result until m_ready frees
//    the output register.
module fifo_task_scheduler_with_await #(
    parameter int MAX_TASKS   = fts_pkg::MAX_TASKS_DEF,
    parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fts_pkg::REQ_W-1:0]   s_req_type,
    input  logic [fts_pkg::IDX_W-1:0]   s_task_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fts_pkg::STAT_W-1:0]  m_status,
    output logic [fts_pkg::IDX_W-1:0]   m_granted_task,
    output logic                        m_await_done_already,
    output logic                        m_running_valid,
    output logic [fts_pkg::IDX_W-1:0]   m_running_task,
    output logic [fts_pkg::TST_W-1:0]   m_addressed_state,
    output logic [fts_pkg::WOKEN_W-1:0] m_woken_count
);
    localparam int TW = $clog2(MAX_TASKS);         // task index
    localparam int CW = $clog2(MAX_TASKS + 1);     // task count
    localparam int QW = $clog2(QUEUE_DEPTH);       // queue pointer
    localparam int FW = $clog2(QUEUE_DEPTH + 1);   // queue fill
    localparam int EW = fts_pkg::TST_W + TW;       // table entry {state, awaited}

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_MARK, S_RPT, S_RES} fsm_t;

    fsm_t            state_reg;
    logic [2:0]      req_reg;
    logic [fts_pkg::IDX_W-1:0] idx_reg;
    logic [CW-1:0]   created_reg;
    logic [QW-1:0]   head_reg, tail_reg;
    logic [FW-1:0]   fill_reg;
    logic [TW-1:0]   cur_reg;
    logic            cv_reg;
    logic [fts_pkg::STAT_W-1:0] status_reg;
    logic [TW-1:0]   granted_reg;
    logic            done_al_reg;
    logic [CW-1:0]   woken_reg;
    logic [CW-1:0]   i_reg;       // scan read pointer
    logic            pv_reg;      // scan data pending
    logic [TW-1:0]   pi_reg;      // index of pending scan data
    logic            pass_reg;    // 0 count, 1 wake

    logic            m_valid_reg;
    logic [fts_pkg::STAT_W-1:0]  m_status_reg;
    logic [fts_pkg::IDX_W-1:0]   m_granted_reg;
    logic                        m_done_reg;
    logic                        m_rv_reg;
    logic [fts_pkg::IDX_W-1:0]   m_rt_reg;
    logic [fts_pkg::TST_W-1:0]   m_as_reg;
    logic [fts_pkg::WOKEN_W-1:0] m_woken_reg;

    // RAM ports
    logic            t_we;
    logic [TW-1:0]   t_waddr, t_raddr;
    logic [EW-1:0]   t_wdata, t_rdata;
    logic            q_we;
    logic [QW-1:0]   q_raddr;
    logic [TW-1:0]   q_wdata, q_rdata;

    fts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_table (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    fts_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(tail_reg), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    logic [fts_pkg::TST_W-1:0] rd_st;
    logic [TW-1:0]   rd_aw;
    logic            known, tab_full, q_full, match, more, scan_end, too_many;
    logic            do_enq, do_deq, do_create, clr_cv, set_cv;
    logic [fts_pkg::STAT_W-1:0] status_next;
    logic [QW-1:0]   tail_next, head_next;
    logic [FW-1:0]   fill_next;

    assign rd_st    = t_rdata[EW-1:TW];
    assign rd_aw    = t_rdata[TW-1:0];
    assign known    = 16'(idx_reg) < 16'(created_reg);
    assign tab_full = created_reg == CW'(MAX_TASKS);
    assign q_full   = fill_reg == FW'(QUEUE_DEPTH);
    assign match    = pv_reg && rd_st == fts_pkg::ST_WAITING && rd_aw == cur_reg;
    assign more     = i_reg < created_reg;
    assign scan_end = !more && !pv_reg;
    assign too_many = 16'(woken_reg) > (16'(QUEUE_DEPTH) - 16'(fill_reg));
    assign q_raddr  = head_reg;

    always_comb begin
        t_we        = 1'b0;
        t_waddr     = cur_reg;
        t_wdata     = {fts_pkg::ST_READY, {TW{1'b0}}};
        t_raddr     = TW'(idx_reg);
        q_we        = 1'b0;
        q_wdata     = cur_reg;
        do_enq      = 1'b0;
        do_deq      = 1'b0;
        do_create   = 1'b0;
        clr_cv      = 1'b0;
        set_cv      = 1'b0;
        status_next = fts_pkg::RES_OK;
        case (state_reg)
            S_IDLE: begin
                t_raddr = TW'(s_task_index);
            end
            S_EXEC: begin
                case (req_reg)
                    fts_pkg::REQ_CREATE: begin
                        if (tab_full) begin
                            status_next = fts_pkg::RES_FULL;
                        end else if (q_full) begin
                            status_next = fts_pkg::RES_BUSY;
                        end else begin
                            do_create = 1'b1;
                            t_we      = 1'b1;
                            t_waddr   = TW'(created_reg);
                            q_wdata   = TW'(created_reg);
                            do_enq    = 1'b1;
                        end
                    end
                    fts_pkg::REQ_DISPATCH: begin
                        if (cv_reg) begin
                            status_next = fts_pkg::RES_BUSY;
                        end else if (fill_reg == '0) begin
                            status_next = fts_pkg::RES_EMPTY;
                        end else begin
                            do_deq  = 1'b1;
                            set_cv  = 1'b1;
                            t_we    = 1'b1;
                            t_waddr = q_rdata;
                            t_wdata = {fts_pkg::ST_RUNNING, {TW{1'b0}}};
                        end
                    end
                    fts_pkg::REQ_YIELD: begin
                        if (!cv_reg) begin
                            status_next = fts_pkg::RES_NORUN;
                        end else if (q_full) begin
                            status_next = fts_pkg::RES_BUSY;
                        end else begin
                            t_we   = 1'b1;
                            do_enq = 1'b1;
                            clr_cv = 1'b1;
                        end
                    end
                    fts_pkg::REQ_AWAIT: begin
                        if (!known) begin
                            status_next = fts_pkg::RES_UNKNOWN;
                        end else if (rd_st == fts_pkg::ST_DONE) begin
                            status_next = fts_pkg::RES_OK;
                        end else if (!cv_reg) begin
                            status_next = fts_pkg::RES_NORUN;
                        end else begin
                            t_we    = 1'b1;
                            t_wdata = {fts_pkg::ST_WAITING, TW'(idx_reg)};
                            clr_cv  = 1'b1;
                        end
                    end
                    fts_pkg::REQ_FINISH: begin
                        if (!cv_reg) begin
                            status_next = fts_pkg::RES_NORUN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                t_raddr = TW'(i_reg);
                if (pass_reg && match) begin
                    t_we    = 1'b1;
                    t_waddr = pi_reg;
                    q_wdata = pi_reg;
                    do_enq  = 1'b1;
                end
                if (!pass_reg && scan_end && too_many) begin
                    status_next = fts_pkg::RES_BUSY;
                end
            end
            S_MARK: begin
                t_we    = 1'b1;
                t_wdata = {fts_pkg::ST_DONE, {TW{1'b0}}};
            end
            default: ;
        endcase
        q_we = do_enq;
    end

    assign tail_next = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_next = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    always_comb begin
        fill_next = fill_reg;
        if (do_enq) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_deq) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    assign s_ready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            created_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            cur_reg     <= '0;
            cv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
            pass_reg    <= 1'b0;
        end else begin
            // taken result; a new one loading in S_RES replaces it there
            if (m_valid_reg && m_ready && state_reg != S_RES) begin
                m_valid_reg <= 1'b0;
            end
            if (do_enq) begin
                tail_reg <= tail_next;
            end
            if (do_deq) begin
                head_reg <= head_next;
            end
            fill_reg <= fill_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_req_type;
                        idx_reg   <= s_task_index;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg  <= status_next;
                    woken_reg   <= '0;
                    i_reg       <= '0;
                    pv_reg      <= 1'b0;
                    pass_reg    <= 1'b0;
                    if (do_create) begin
                        granted_reg <= TW'(created_reg);
                    end else if (set_cv) begin
                        granted_reg <= q_rdata;
                    end else begin
                        granted_reg <= '0;
                    end
                    if (do_create) begin
                        created_reg <= created_reg + 1'b1;
                    end
                    if (set_cv) begin
                        cur_reg <= q_rdata;
                        cv_reg  <= 1'b1;
                    end
                    if (clr_cv) begin
                        cv_reg <= 1'b0;
                    end
                    done_al_reg <= req_reg == fts_pkg::REQ_AWAIT && known
                            && rd_st == fts_pkg::ST_DONE;
                    state_reg <= (req_reg == fts_pkg::REQ_FINISH && cv_reg) ? S_SCAN : S_RPT;
                end
                S_SCAN: begin
                    pv_reg <= more;
                    pi_reg <= TW'(i_reg);
                    if (more) begin
                        i_reg <= i_reg + 1'b1;
                    end
                    if (!pass_reg && match) begin
                        woken_reg <= woken_reg + 1'b1;
                    end
                    if (scan_end) begin
                        if (pass_reg) begin
                            cv_reg    <= 1'b0;
                            state_reg <= S_RPT;
                        end else if (too_many) begin
                            status_reg <= status_next;
                            woken_reg  <= '0;
                            state_reg  <= S_RPT;
                        end else begin
                            state_reg <= S_MARK;
                        end
                    end
                end
                S_MARK: begin
                    i_reg     <= '0;
                    pv_reg    <= 1'b0;
                    pass_reg  <= 1'b1;
                    state_reg <= S_SCAN;
                end
                S_RPT: begin
                    // table read of the addressed task is in flight
                    state_reg <= S_RES;
                end
                S_RES: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= status_reg;
                        m_granted_reg <= fts_pkg::IDX_W'(granted_reg);
                        m_done_reg    <= done_al_reg;
                        m_rv_reg      <= cv_reg;
                        m_rt_reg      <= cv_reg ? fts_pkg::IDX_W'(cur_reg) : '0;
                        m_as_reg      <= known ? rd_st : fts_pkg::ST_READY;
                        m_woken_reg   <= fts_pkg::WOKEN_W'(woken_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_granted_task       = m_granted_reg;
    assign m_await_done_already = m_done_reg;
    assign m_running_valid      = m_rv_reg;
    assign m_running_task       = m_rt_reg;
    assign m_addressed_state    = m_as_reg;
    assign m_woken_count        = m_woken_reg;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        16'(fill_reg) <= 16'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_created_range: assert property (@(posedge aclk) disable iff (!aresetn)
        16'(created_reg) <= 16'(MAX_TASKS))
        else $error("task count beyond table size");

    a_run_created: assert property (@(posedge aclk) disable iff (!aresetn)
        cv_reg |-> 16'(cur_reg) < 16'(created_reg))
        else $error("running task was never created");

    a_wake_space: assert property (@(posedge aclk) disable iff (!aresetn)
        do_enq |-> !q_full)
        else $error("enqueue into a full run queue");
endmodule

>>> sv/fts_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> tb/fifo_task_scheduler_with_await_tb.sv
`timescale 1ns / 100ps
// Testbench for fifo_task_scheduler_with_await: random and directed requests
// checked item by item against a scheduler model. Depends on fts_pkg and the RTL.
module fifo_task_scheduler_with_await_tb;

    localparam int NTASK  = fts_pkg::MAX_TASKS_DEF;
    localparam int QDEPTH = fts_pkg::QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IW = fts_pkg::IDX_W;

    typedef struct packed {
        logic [fts_pkg::REQ_W-1:0] req;
        logic [fts_pkg::IDX_W-1:0] idx;
    } request_t;

    typedef struct packed {
        logic [fts_pkg::STAT_W-1:0]  status;
        logic [fts_pkg::IDX_W-1:0]   granted;
        logic                        done_already;
        logic                        run_valid;
        logic [fts_pkg::IDX_W-1:0]   run_task;
        logic [fts_pkg::TST_W-1:0]   addr_state;
        logic [fts_pkg::WOKEN_W-1:0] woken;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [fts_pkg::REQ_W-1:0] s_req_type = '0;
    logic [fts_pkg::IDX_W-1:0] s_task_index = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [fts_pkg::STAT_W-1:0] m_status;
    logic [fts_pkg::IDX_W-1:0] m_granted_task;
    logic m_await_done_already;
    logic m_running_valid;
    logic [fts_pkg::IDX_W-1:0] m_running_task;
    logic [fts_pkg::TST_W-1:0] m_addressed_state;
    logic [fts_pkg::WOKEN_W-1:0] m_woken_count;

    fifo_task_scheduler_with_await dut (.*);

    // Model state of the scheduler
    fts_pkg::tstate_t    mdl_state [NTASK];
    logic [IW-1:0]       mdl_awaits [NTASK];
    int                  mdl_created;
    int                  mdl_runq [$];
    int                  mdl_cur;
    bit                  mdl_cur_valid;

    request_t pending_reqs [$];
    outcome_t expected_outcomes [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    // handshake flags from the last rising edge, and idle counters
    logic s_acc_q = 1'b0;
    logic m_acc_q = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;

    function automatic outcome_t schedule_step(request_t r);
        outcome_t o;
        int n;
        o = '0;
        o.status = fts_pkg::RES_OK;
        case (r.req)
            fts_pkg::REQ_CREATE: begin
                if (mdl_created >= NTASK) o.status = fts_pkg::RES_FULL;
                else if (mdl_runq.size() >= QDEPTH) o.status = fts_pkg::RES_BUSY;
                else begin
                    o.granted = IW'(mdl_created);
                    mdl_state[mdl_created] = fts_pkg::ST_READY;
                    mdl_awaits[mdl_created] = '0;
                    mdl_runq.push_back(mdl_created);
                    mdl_created++;
                end
            end
            fts_pkg::REQ_DISPATCH: begin
                if (mdl_cur_valid) o.status = fts_pkg::RES_BUSY;
                else if (mdl_runq.size() == 0) o.status = fts_pkg::RES_EMPTY;
                else begin
                    mdl_cur = mdl_runq.pop_front();
                    o.granted = IW'(mdl_cur);
                    mdl_state[mdl_cur] = fts_pkg::ST_RUNNING;
                    mdl_cur_valid = 1'b1;
                end
            end
            fts_pkg::REQ_YIELD: begin
                if (!mdl_cur_valid) o.status = fts_pkg::RES_NORUN;
                else if (mdl_runq.size() >= QDEPTH) o.status = fts_pkg::RES_BUSY;
                else begin
                    mdl_state[mdl_cur] = fts_pkg::ST_READY;
                    mdl_runq.push_back(mdl_cur);
                    mdl_cur_valid = 1'b0;
                end
            end
            fts_pkg::REQ_AWAIT: begin
                if (r.idx >= mdl_created) o.status = fts_pkg::RES_UNKNOWN;
                else if (mdl_state[r.idx] == fts_pkg::ST_DONE) o.done_already = 1'b1;
                else if (!mdl_cur_valid) o.status = fts_pkg::RES_NORUN;
                else begin
                    mdl_state[mdl_cur] = fts_pkg::ST_WAITING;
                    mdl_awaits[mdl_cur] = r.idx;
                    mdl_cur_valid = 1'b0;
                end
            end
            fts_pkg::REQ_FINISH: begin
                if (!mdl_cur_valid) o.status = fts_pkg::RES_NORUN;
                else begin
                    n = 0;
                    for (int i = 0; i < mdl_created; i++)
                        if (mdl_state[i] == fts_pkg::ST_WAITING && mdl_awaits[i] == mdl_cur)
                            n++;
                    if (n > QDEPTH - mdl_runq.size()) o.status = fts_pkg::RES_BUSY;
                    else begin
                        o.woken = fts_pkg::WOKEN_W'(n);
                        mdl_state[mdl_cur] = fts_pkg::ST_DONE;
                        for (int i = 0; i < mdl_created; i++)
                            if (mdl_state[i] == fts_pkg::ST_WAITING
                                    && mdl_awaits[i] == mdl_cur) begin
                                mdl_state[i] = fts_pkg::ST_READY;
                                mdl_awaits[i] = '0;
                                mdl_runq.push_back(i);
                            end
                        mdl_cur_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        o.run_valid = mdl_cur_valid;
        o.run_task = mdl_cur_valid ? mdl_cur[IW-1:0] : '0;
        o.addr_state = (r.idx < mdl_created) ? mdl_state[r.idx] : fts_pkg::ST_READY;
        return o;
    endfunction

    task automatic add_req(input logic [fts_pkg::REQ_W-1:0] rq, input logic [IW-1:0] ix);
        request_t r;
        r.req = rq;
        r.idx = ix;
        pending_reqs.push_back(r);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stimulus. Index is kept below created count mostly so the table is exercised;
    // out-of-range indexes only exercise the unknown-task path; unwritten entries read are never used.
    initial begin
        int ncreated;
        int roll;
        ncreated = 0;
        // directed: empty-queue dispatch, no-run cases, unknown await, odd opcodes
        add_req(fts_pkg::REQ_DISPATCH, 9'd0);
        add_req(fts_pkg::REQ_YIELD, 9'd0);
        add_req(fts_pkg::REQ_FINISH, 9'd511);
        add_req(fts_pkg::REQ_AWAIT, 9'd511);
        add_req(3'd5, 9'd0);
        add_req(3'd6, 9'd511);
        add_req(3'd7, 9'd170);
        add_req(fts_pkg::REQ_CREATE, 9'd0);
        add_req(fts_pkg::REQ_CREATE, 9'd1);
        add_req(fts_pkg::REQ_CREATE, 9'd2);
        ncreated = 3;
        add_req(fts_pkg::REQ_DISPATCH, 9'd0);   // task 0 runs
        add_req(fts_pkg::REQ_DISPATCH, 9'd0);   // busy
        add_req(fts_pkg::REQ_AWAIT, 9'd0);      // waits on itself
        add_req(fts_pkg::REQ_DISPATCH, 9'd1);   // task 1 runs
        add_req(fts_pkg::REQ_AWAIT, 9'd2);      // task 1 waits on 2
        add_req(fts_pkg::REQ_DISPATCH, 9'd2);   // task 2 runs
        add_req(fts_pkg::REQ_FINISH, 9'd1);     // wakes task 1
        add_req(fts_pkg::REQ_AWAIT, 9'd2);      // done already, no running task
        add_req(fts_pkg::REQ_DISPATCH, 9'd1);
        add_req(fts_pkg::REQ_YIELD, 9'd1);
        add_req(fts_pkg::REQ_AWAIT, 9'd2);      // done already
        add_req(fts_pkg::REQ_AWAIT, 9'd0);      // live, no running task
        for (int k = 0; k < 1312; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                add_req(3'($urandom_range(5, 7)), 9'($urandom));
            else if (roll < 18) begin
                add_req(fts_pkg::REQ_CREATE, 9'($urandom));
                if (ncreated < NTASK) ncreated++;
            end else if (roll < 45)
                add_req(fts_pkg::REQ_DISPATCH, 9'($urandom_range(0, ncreated - 1)));
            else if (roll < 60)
                add_req(fts_pkg::REQ_YIELD, 9'($urandom_range(0, ncreated - 1)));
            else if (roll < 78)
                add_req(fts_pkg::REQ_AWAIT, (roll < 62) ? 9'($urandom) :
                        9'($urandom_range(0, ncreated - 1)));
            else
                add_req(fts_pkg::REQ_FINISH, 9'($urandom_range(0, ncreated - 1)));
        end
        // fill the table to reach table-full
        for (int k = 0; k < NTASK + 3; k++) add_req(fts_pkg::REQ_CREATE, 9'h1ff);
        add_req(fts_pkg::REQ_AWAIT, 9'h1ff);
        stim_done = 1'b1;
    end

    // Reset and model init
    initial begin
        mdl_created = 0;
        mdl_cur = 0;
        mdl_cur_valid = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: presents items at the falling edge after a random gap per item
    always @(negedge aclk) begin
        int gap;
        gap = src_gap;
        if (aresetn && (!s_valid || s_acc_q)) begin
            if (s_valid) gap = $urandom_range(0, 11);   // item went at last rising edge
            if (gap > 0) begin
                s_valid <= 1'b0;
                gap = gap - 1;
            end else if (pending_reqs.size() > 0) begin
                s_valid <= 1'b1;
                s_req_type <= pending_reqs[0].req;
                s_task_index <= pending_reqs[0].idx;
                void'(pending_reqs.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
        src_gap <= gap;
    end

    // Capture of input handshakes at the rising edge
    always @(posedge aclk) begin
        s_acc_q <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_outcomes.push_back(schedule_step({s_req_type, s_task_index}));
        end
    end

    // Receiver: random stall per result
    always @(negedge aclk) begin
        int gap;
        gap = sink_gap;
        if (m_acc_q) gap = $urandom_range(0, 11);
        if (gap > 0) begin
            m_ready <= 1'b0;
            gap = gap - 1;
        end else begin
            m_ready <= 1'b1;
        end
        sink_gap <= gap;
    end

    // Monitor: compare each accepted result against the oldest expectation
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t exp_o;
        m_acc_q <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_granted_task, m_await_done_already, m_running_valid,
                   m_running_task, m_addressed_state, m_woken_count};
            if (expected_outcomes.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result %p", got);
            end else begin
                exp_o = expected_outcomes.pop_front();
                if (got !== exp_o) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("mismatch exp %p got %p", exp_o, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
            if (stim_done && pending_reqs.size() == 0 && !s_valid &&
                expected_outcomes.size() == 0) begin
                repeat (40) @(posedge aclk);
                if (errors == 0 && expected_outcomes.size() == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
